### hw/rtl/iirf4_pkg.sv
package iirf4_pkg;

    // Fixed-point layout shared by coefficients and delay states
    localparam int FRAC_BITS = 20;
    // Initial-condition fields are 32-bit signed values
    localparam int INIT_W = 32;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    localparam int COEF_SEL_W = 4;
    localparam int Z_IDX_W    = 2;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_COEF_B0_B1 = 3'd0,
        REG_COEF_B2_B3 = 3'd1,
        REG_COEF_B4_A1 = 3'd2,
        REG_COEF_A2_A3 = 3'd3,
        REG_COEF_A4    = 3'd4,
        REG_INIT_Z0_Z1 = 3'd5,
        REG_INIT_Z2_Z3 = 3'd6
    } cfg_reg_t;

    // Coefficient picked for the shared multiplier
    typedef enum logic [COEF_SEL_W-1:0] {
        C_B0 = 4'd0,
        C_B1 = 4'd1,
        C_B2 = 4'd2,
        C_B3 = 4'd3,
        C_B4 = 4'd4,
        C_A1 = 4'd5,
        C_A2 = 4'd6,
        C_A3 = 4'd7,
        C_A4 = 4'd8
    } coef_sel_t;

    // Second multiplier operand: input sample, integer or fraction part of y
    typedef enum logic [1:0] {
        OPND_X  = 2'd0,
        OPND_HI = 2'd1,
        OPND_LO = 2'd2
    } opnd_sel_t;

    // Accumulator operations on the registered product
    typedef enum logic [2:0] {
        ACC_HOLD      = 3'd0,
        ACC_INIT_ADD  = 3'd1,
        ACC_INIT_RSUB = 3'd2,
        ACC_ADD       = 3'd3,
        ACC_SUB       = 3'd4
    } acc_op_t;

    // Phase within one feedback branch
    typedef enum logic [1:0] {
        PH_LO = 2'd0,
        PH_HI = 2'd1,
        PH_X  = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_Y_MUL    = 3'd1,
        ST_Y_ACC    = 3'd2,
        ST_Y_FIN    = 3'd3,
        ST_BRANCH   = 3'd4,
        ST_TAIL_ADD = 3'd5,
        ST_TAIL_WB  = 3'd6,
        ST_DONE     = 3'd7
    } state_t;

    localparam logic [Z_IDX_W-1:0] BR_LAST = 2'd3;

    typedef struct packed {
        coef_sel_t            mul_coef;
        opnd_sel_t            mul_opnd;
        acc_op_t              acc_op;
        logic [Z_IDX_W-1:0]   base_idx;
        logic                 base_zero;
        logic                 wb_en;
        logic [Z_IDX_W-1:0]   wb_idx;
        logic                 y_fin;
        logic                 load;
        logic                 out_load;
    } iirf4_cmd_t;

    typedef struct packed {
        logic out_free;
    } iirf4_sts_t;

endpackage

### hw/rtl/iirf4_ctrl.sv
module iirf4_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  iirf4_pkg::iirf4_sts_t sts,
    output iirf4_pkg::iirf4_cmd_t cmd
);
    import iirf4_pkg::*;

    state_t               state_reg, state_next;
    phase_t               phase_reg, phase_next;
    logic [Z_IDX_W-1:0]   br_reg, br_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_LO;
            br_reg    <= '0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            br_reg    <= br_next;
        end
    end

    // Next state and branch/phase counters
    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        br_next    = br_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_Y_MUL;
                end
            end
            ST_Y_MUL: state_next = ST_Y_ACC;
            ST_Y_ACC: state_next = ST_Y_FIN;
            ST_Y_FIN: begin
                state_next = ST_BRANCH;
                phase_next = PH_LO;
                br_next    = '0;
            end
            ST_BRANCH: begin
                case (phase_reg)
                    PH_LO: phase_next = PH_HI;
                    PH_HI: phase_next = PH_X;
                    default: begin
                        phase_next = PH_LO;
                        if (br_reg == BR_LAST) begin
                            br_next    = '0;
                            state_next = ST_TAIL_ADD;
                        end else begin
                            br_next = br_reg + 1'b1;
                        end
                    end
                endcase
            end
            ST_TAIL_ADD: state_next = ST_TAIL_WB;
            ST_TAIL_WB:  state_next = ST_DONE;
            ST_DONE: begin
                if (sts.out_free) begin
                    state_next = s_tvalid ? ST_Y_MUL : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Command decode
    always_comb begin
        cmd          = '0;
        cmd.mul_coef = C_B0;
        cmd.mul_opnd = OPND_X;
        cmd.acc_op   = ACC_HOLD;
        s_tready     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_Y_MUL: begin
                cmd.mul_coef = C_B0;
                cmd.mul_opnd = OPND_X;
            end
            ST_Y_ACC: begin
                cmd.acc_op   = ACC_INIT_ADD;
                cmd.base_idx = '0;
            end
            ST_Y_FIN: begin
                cmd.y_fin = 1'b1;
            end
            ST_BRANCH: begin
                case (phase_reg)
                    PH_LO: begin
                        cmd.mul_coef = coef_sel_t'(COEF_SEL_W'(C_A1) + COEF_SEL_W'(br_reg));
                        cmd.mul_opnd = OPND_LO;
                        // finish the previous branch sum
                        if (br_reg != '0) begin
                            cmd.acc_op = ACC_ADD;
                        end
                    end
                    PH_HI: begin
                        cmd.mul_coef  = coef_sel_t'(COEF_SEL_W'(C_A1) + COEF_SEL_W'(br_reg));
                        cmd.mul_opnd  = OPND_HI;
                        cmd.acc_op    = ACC_INIT_RSUB;
                        cmd.base_idx  = br_reg + 1'b1;
                        cmd.base_zero = (br_reg == BR_LAST);
                        cmd.wb_en     = (br_reg != '0);
                        cmd.wb_idx    = br_reg - 1'b1;
                    end
                    default: begin
                        cmd.mul_coef = coef_sel_t'(COEF_SEL_W'(C_B1) + COEF_SEL_W'(br_reg));
                        cmd.mul_opnd = OPND_X;
                        cmd.acc_op   = ACC_SUB;
                    end
                endcase
            end
            ST_TAIL_ADD: begin
                cmd.acc_op = ACC_ADD;
            end
            ST_TAIL_WB: begin
                cmd.wb_en  = 1'b1;
                cmd.wb_idx = BR_LAST;
            end
            ST_DONE: begin
                cmd.out_load = sts.out_free;
                s_tready     = sts.out_free;
                cmd.load     = sts.out_free && s_tvalid;
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_load_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> state_reg == ST_Y_MUL)
        else $error("accepted sample did not start the multiply sequence");

    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("result pushed into a full output register");

    a_last_branch: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BRANCH && phase_reg == PH_X && br_reg == BR_LAST)
        |=> state_reg == ST_TAIL_ADD)
        else $error("branch sequence did not end after the fourth branch");

    a_phase_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_BRANCH |-> phase_reg == PH_LO)
        else $error("phase counter not cleared outside the branch loop");
`endif

endmodule

### hw/rtl/iirf4_datapath.sv
module iirf4_datapath #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEF_WIDTH   = 24,
    parameter int STATE_WIDTH  = 40
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    input  logic [iirf4_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [iirf4_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [SAMPLE_WIDTH-1:0]             sample_in,
    input  logic                                restart,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [SAMPLE_WIDTH-1:0]             sample_out,
    output logic                                overflow,
    input  iirf4_pkg::iirf4_cmd_t               cmd,
    output iirf4_pkg::iirf4_sts_t               sts
);
    import iirf4_pkg::*;

    localparam int HI_W   = STATE_WIDTH - FRAC_BITS;
    localparam int LO_W   = FRAC_BITS + 1;
    localparam int MB0_W  = (SAMPLE_WIDTH > HI_W) ? SAMPLE_WIDTH : HI_W;
    localparam int MB_W   = (MB0_W > LO_W) ? MB0_W : LO_W;
    localparam int PROD_W = COEF_WIDTH + MB_W;
    localparam int A0_W   = (PROD_W > STATE_WIDTH) ? PROD_W : STATE_WIDTH;
    localparam int A1_W   = (A0_W > SAMPLE_WIDTH + FRAC_BITS) ? A0_W
                                                              : SAMPLE_WIDTH + FRAC_BITS;
    localparam int ACC_W  = A1_W + 2;
    localparam int PRND_W = PROD_W + 1 - FRAC_BITS;
    localparam int RND_W  = ACC_W + 1 - FRAC_BITS;

    localparam logic signed [PROD_W:0] PROD_HALF =
        {{(PROD_W + 1 - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};
    localparam logic signed [ACC_W:0] ACC_HALF =
        {{(ACC_W + 1 - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};

    // Configuration registers
    logic [2*COEF_WIDTH-1:0] coef_b0_b1_reg, coef_b2_b3_reg, coef_b4_a1_reg, coef_a2_a3_reg;
    logic [COEF_WIDTH-1:0]   coef_a4_reg;
    logic [CFG_DATA_W-1:0]   init_z0_z1_reg, init_z2_z3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_b0_b1_reg <= '0;
            coef_b2_b3_reg <= '0;
            coef_b4_a1_reg <= '0;
            coef_a2_a3_reg <= '0;
            coef_a4_reg    <= '0;
            init_z0_z1_reg <= '0;
            init_z2_z3_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_COEF_B0_B1: coef_b0_b1_reg <= cfg_data[2*COEF_WIDTH-1:0];
                REG_COEF_B2_B3: coef_b2_b3_reg <= cfg_data[2*COEF_WIDTH-1:0];
                REG_COEF_B4_A1: coef_b4_a1_reg <= cfg_data[2*COEF_WIDTH-1:0];
                REG_COEF_A2_A3: coef_a2_a3_reg <= cfg_data[2*COEF_WIDTH-1:0];
                REG_COEF_A4:    coef_a4_reg    <= cfg_data[COEF_WIDTH-1:0];
                REG_INIT_Z0_Z1: init_z0_z1_reg <= cfg_data;
                REG_INIT_Z2_Z3: init_z2_z3_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Working registers
    logic signed [SAMPLE_WIDTH-1:0] x_reg;
    logic signed [STATE_WIDTH-1:0]  z_reg [4];
    logic signed [STATE_WIDTH-1:0]  yfb_reg;
    logic        [SAMPLE_WIDTH-1:0] yout_reg;
    logic                           ovf_reg;
    logic signed [PROD_W-1:0]       prod_reg;
    logic signed [ACC_W-1:0]        acc_reg, acc_next;

    // Multiplier operands
    logic signed [COEF_WIDTH-1:0] coef_sel;
    logic signed [MB_W-1:0]       opnd;
    logic signed [HI_W-1:0]       y_hi;
    logic signed [LO_W-1:0]       y_lo;

    assign y_hi = yfb_reg[STATE_WIDTH-1:FRAC_BITS];
    assign y_lo = {1'b0, yfb_reg[FRAC_BITS-1:0]};

    always_comb begin
        case (cmd.mul_coef)
            C_B0:    coef_sel = coef_b0_b1_reg[COEF_WIDTH-1:0];
            C_B1:    coef_sel = coef_b0_b1_reg[2*COEF_WIDTH-1:COEF_WIDTH];
            C_B2:    coef_sel = coef_b2_b3_reg[COEF_WIDTH-1:0];
            C_B3:    coef_sel = coef_b2_b3_reg[2*COEF_WIDTH-1:COEF_WIDTH];
            C_B4:    coef_sel = coef_b4_a1_reg[COEF_WIDTH-1:0];
            C_A1:    coef_sel = coef_b4_a1_reg[2*COEF_WIDTH-1:COEF_WIDTH];
            C_A2:    coef_sel = coef_a2_a3_reg[COEF_WIDTH-1:0];
            C_A3:    coef_sel = coef_a2_a3_reg[2*COEF_WIDTH-1:COEF_WIDTH];
            C_A4:    coef_sel = coef_a4_reg;
            default: coef_sel = '0;
        endcase
    end

    always_comb begin
        case (cmd.mul_opnd)
            OPND_X:  opnd = MB_W'(x_reg);
            OPND_HI: opnd = MB_W'(y_hi);
            OPND_LO: opnd = MB_W'(y_lo);
            default: opnd = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= coef_sel * opnd;
    end

    // Product rounded from 40 to 20 fraction bits, half up
    logic signed [PROD_W:0]       prod_half;
    logic signed [PRND_W-1:0]     prod_rnd;
    logic signed [ACC_W-1:0]      prod_ext, base;

    assign prod_half = {prod_reg[PROD_W-1], prod_reg} + PROD_HALF;
    assign prod_rnd  = prod_half[PROD_W:FRAC_BITS];
    assign prod_ext  = ACC_W'(prod_reg);
    assign base      = cmd.base_zero ? '0 : ACC_W'(z_reg[cmd.base_idx]);

    always_comb begin
        case (cmd.acc_op)
            ACC_INIT_ADD:  acc_next = base + prod_ext;
            ACC_INIT_RSUB: acc_next = base - ACC_W'(prod_rnd);
            ACC_ADD:       acc_next = acc_reg + prod_ext;
            ACC_SUB:       acc_next = acc_reg - prod_ext;
            default:       acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    // Saturate accumulator to state width
    logic                          st_pos, st_neg;
    logic signed [STATE_WIDTH-1:0] acc_sat;

    assign st_pos  = !acc_reg[ACC_W-1] && (|acc_reg[ACC_W-2:STATE_WIDTH-1]);
    assign st_neg  = acc_reg[ACC_W-1] && !(&acc_reg[ACC_W-2:STATE_WIDTH-1]);
    assign acc_sat = st_pos ? {1'b0, {(STATE_WIDTH-1){1'b1}}} :
                     st_neg ? {1'b1, {(STATE_WIDTH-1){1'b0}}} :
                              acc_reg[STATE_WIDTH-1:0];

    // Round y to an integer and saturate to sample width
    logic signed [ACC_W:0]       acc_half;
    logic        [RND_W-1:0]     y_rnd;
    logic                        y_pos, y_neg;
    logic        [SAMPLE_WIDTH-1:0] y_sat;

    assign acc_half = {acc_reg[ACC_W-1], acc_reg} + ACC_HALF;
    assign y_rnd    = acc_half[ACC_W:FRAC_BITS];
    assign y_pos    = !y_rnd[RND_W-1] && (|y_rnd[RND_W-2:SAMPLE_WIDTH-1]);
    assign y_neg    = y_rnd[RND_W-1] && !(&y_rnd[RND_W-2:SAMPLE_WIDTH-1]);
    assign y_sat    = y_pos ? {1'b0, {(SAMPLE_WIDTH-1){1'b1}}} :
                      y_neg ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}} :
                              y_rnd[SAMPLE_WIDTH-1:0];

    // Delay states, sample and flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 4; k++) begin
                z_reg[k] <= '0;
            end
            ovf_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                ovf_reg <= 1'b0;
                if (restart) begin
                    z_reg[0] <= STATE_WIDTH'($signed(init_z0_z1_reg[INIT_W-1:0]));
                    z_reg[1] <= STATE_WIDTH'($signed(init_z0_z1_reg[2*INIT_W-1:INIT_W]));
                    z_reg[2] <= STATE_WIDTH'($signed(init_z2_z3_reg[INIT_W-1:0]));
                    z_reg[3] <= STATE_WIDTH'($signed(init_z2_z3_reg[2*INIT_W-1:INIT_W]));
                end
            end
            if (cmd.y_fin) begin
                ovf_reg <= ovf_reg | st_pos | st_neg | y_pos | y_neg;
            end
            if (cmd.wb_en) begin
                z_reg[cmd.wb_idx] <= acc_sat;
                ovf_reg           <= ovf_reg | st_pos | st_neg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x_reg <= sample_in;
        end
        if (cmd.y_fin) begin
            yfb_reg  <= acc_sat;
            yout_reg <= y_sat;
        end
    end

    // Output register
    logic                    m_tvalid_reg;
    logic [SAMPLE_WIDTH-1:0] out_sample_reg;
    logic                    out_ovf_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_sample_reg <= yout_reg;
            out_ovf_reg    <= ovf_reg;
        end
    end

    assign m_tvalid     = m_tvalid_reg;
    assign sample_out   = out_sample_reg;
    assign overflow     = out_ovf_reg;
    assign sts.out_free = !m_tvalid_reg || m_tready;

`ifndef SYNTHESIS
    a_out_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_tvalid_reg)
        else $error("output register not valid after a result was loaded");

    a_no_wb_on_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> !cmd.wb_en && !cmd.y_fin)
        else $error("state writeback collides with sample load");
`endif

endmodule

### hw/rtl/iir_filter_fourth_order.sv
// Fourth-order IIR filter, transposed direct form II, a0 normalized to 1.
// Input channel (s_*): one signed sample per beat in s_tdata; s_tuser set
//   reloads the four delay states from the initial-condition registers
//   before that sample is filtered.
// Result channel (m_*): rounded, saturated output sample in m_tdata;
//   m_tuser flags that the output, the feedback value or a delay state
//   saturated while this sample was processed.
// Config channel (cfg_*): one register per beat, always ready; write only
//   while the filter is idle.
// Samples are processed one at a time: nine coefficients share one
//   multiplier over thirteen products (b0*x, then per branch a*y_lo, a*y_hi
//   and b*x), one product per cycle, plus accumulate and writeback steps.
// The next input beat is taken in the same cycle the result enters the
//   output register; a result waiting there does not stall the next sample.
// If the receiver stalls, the finished result holds in the output register;
//   the following sample runs to completion and then waits for room.
// Reset (synchronous, active low) clears FSM, config, delay states and flags.
module iir_filter_fourth_order #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEF_WIDTH   = 24,
    parameter int STATE_WIDTH  = 40
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // Input beats
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      s_tdata,  // sample_in
    input  logic                                   s_tuser,  // restart
    // Result beats
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      m_tdata,  // sample_out
    output logic                                   m_tuser,  // overflow
    // Register writes
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [iirf4_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [iirf4_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import iirf4_pkg::*;

    localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

    iirf4_cmd_t cmd;
    iirf4_sts_t sts;
    logic [SAMPLE_WIDTH-1:0] sample_out;

    // Registers are plain flops, so writes are always accepted
    assign cfg_ready = 1'b1;

    iirf4_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    iirf4_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH),
        .STATE_WIDTH  (STATE_WIDTH)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample_in  (s_tdata[SAMPLE_WIDTH-1:0]),
        .restart    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .sample_out (sample_out),
        .overflow   (m_tuser),
        .cmd        (cmd),
        .sts        (sts)
    );

    // Pad the sample with zeros up to a whole byte
    assign m_tdata = TDATA_W'(sample_out);

endmodule
